>>> src/aesenc_pkg.sv
package aesenc_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned NumStages = NumRounds + 1;

   // Configuration register indexes.
   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow  = 1'b1;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   localparam byte_type Sbox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Round constant used when deriving the key of round r (index 0 unused).
   localparam byte_type Rcon [NumStages] = '{
      8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic byte_type get_byte(block_type b, int unsigned idx);
      return b[127 - 8*idx -: 8];
   endfunction

   function automatic byte_type gf_dbl(byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes followed by ShiftRows; byte 4c+r is row r of column c.
   function automatic block_type sub_shift(block_type s);
      block_type t;
      t = '0;
      for (int unsigned c = 0; c < 4; c++) begin
         for (int unsigned r = 0; r < 4; r++) begin
            t[127 - 8*(c*4+r) -: 8] = Sbox[get_byte(s, ((c + r) % 4) * 4 + r)];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(block_type s);
      block_type t;
      byte_type a0, a1, a2, a3, all;
      t = '0;
      for (int unsigned c = 0; c < 4; c++) begin
         a0  = get_byte(s, c*4);
         a1  = get_byte(s, c*4 + 1);
         a2  = get_byte(s, c*4 + 2);
         a3  = get_byte(s, c*4 + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 8*(c*4)     -: 8] = a0 ^ all ^ gf_dbl(a0 ^ a1);
         t[127 - 8*(c*4 + 1) -: 8] = a1 ^ all ^ gf_dbl(a1 ^ a2);
         t[127 - 8*(c*4 + 2) -: 8] = a2 ^ all ^ gf_dbl(a2 ^ a3);
         t[127 - 8*(c*4 + 3) -: 8] = a3 ^ all ^ gf_dbl(a3 ^ a0);
      end
      return t;
   endfunction

   // Derives the next round key from the previous one.
   function automatic block_type key_next(block_type rk, byte_type rc);
      logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
      w0 = rk[127:96];
      w1 = rk[95:64];
      w2 = rk[63:32];
      w3 = rk[31:0];
      t  = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

>>> src/aesenc_if.sv
interface aesenc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_high;
   logic [63:0] plain_low;
   modport source (output valid, output plain_high, output plain_low, input ready);
   modport sink (input valid, input plain_high, input plain_low, output ready);
endinterface

interface aesenc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;
   modport source (output valid, output cipher_high, output cipher_low, input ready);
   modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface aesenc_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/aes128_block_encrypt_core.sv
// Channel   Direction  Transaction
// req_chan  in         one 128-bit plaintext block (plain_high, plain_low)
// rsp_chan  out        one 128-bit ciphertext block (cipher_high, cipher_low)
// csr_chan  in         one 64-bit key half, index 0 = high half, 1 = low half
//
// Eleven register stages: the initial key addition, then one AES round each.
// One block may enter every cycle while the first stage is not held by a stall.
// The round keys travel down the pipe beside the data, each stage deriving its
// own key from the previous one. Reset (synchronous) empties the pipe and
// zeroes the key. A stalled output only holds the stages that are full up to
// it; empty stages further back keep absorbing transactions.
module aes128_block_encrypt_core (
   input  logic  clock,
   input  logic  reset,
   aesenc_req_if.sink   req_chan,
   aesenc_rsp_if.source rsp_chan,
   aesenc_csr_if.sink   csr_chan
);

   localparam int unsigned Last = aesenc_pkg::NumStages - 1;

   logic [63:0] key_high_ff, key_low_ff;

   aesenc_pkg::block_type st_ff [aesenc_pkg::NumStages];
   aesenc_pkg::block_type rk_ff [aesenc_pkg::NumStages];
   aesenc_pkg::block_type st_in [aesenc_pkg::NumStages];
   aesenc_pkg::block_type rk_in [aesenc_pkg::NumStages];
   logic [Last:0]         vld_ff, vld_in, rdy;

   // The key registers are always ready to take a write.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            aesenc_pkg::CsrKeyHigh: key_high_ff <= csr_chan.data;
            aesenc_pkg::CsrKeyLow:  key_low_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or its contents move on this cycle.
   always_comb begin
      rdy[Last] = !vld_ff[Last] || rsp_chan.ready;
      for (int i = Last - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign req_chan.ready = rdy[0];

   always_comb begin
      rk_in[0]  = {key_high_ff, key_low_ff};
      st_in[0]  = {req_chan.plain_high, req_chan.plain_low} ^ rk_in[0];
      vld_in[0] = req_chan.valid;
      for (int unsigned i = 1; i < aesenc_pkg::NumStages; i++) begin
         rk_in[i]  = aesenc_pkg::key_next(rk_ff[i-1], aesenc_pkg::Rcon[i]);
         vld_in[i] = vld_ff[i-1];
         if (i == Last) begin
            // The final round has no column mixing.
            st_in[i] = aesenc_pkg::sub_shift(st_ff[i-1]) ^ rk_in[i];
         end else begin
            st_in[i] = aesenc_pkg::mix_columns(aesenc_pkg::sub_shift(st_ff[i-1])) ^ rk_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int unsigned i = 0; i < aesenc_pkg::NumStages; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned i = 0; i < aesenc_pkg::NumStages; i++) begin
         if (rdy[i]) begin
            st_ff[i] <= st_in[i];
            rk_ff[i] <= rk_in[i];
         end
      end
   end

   assign rsp_chan.valid       = vld_ff[Last];
   assign rsp_chan.cipher_high = st_ff[Last][127:64];
   assign rsp_chan.cipher_low  = st_ff[Last][63:0];

`ifndef NO_ASSERTIONS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted block did not enter the first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[Last-1] && !rdy[Last-1] |=> vld_ff[Last-1] && $stable(st_ff[Last-1]))
      else $error("stalled round stage lost its block");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> vld_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule
